/* rtl/ipv4_header_parse_check_core_assert.svh */
// ----------------------------------------------------------------------------
// IPv4 header parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_PARSE_CHECK_CORE_ASSERT_SVH
`define IPV4_HEADER_PARSE_CHECK_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IHPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ihpc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IHPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ihpc assertion failed");

`endif

/* rtl/ihpc_pkg.sv */
// ----------------------------------------------------------------------------
// IPv4 header parser package
// Result kinds, the result record and fixed header constants.
// ----------------------------------------------------------------------------
package ihpc_pkg;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_SUMMARY   = 2'd1,
        KIND_SHORT     = 2'd2,
        KIND_MALFORMED = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [7:0]  tos;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [5:0]  header_bytes;
        logic [15:0] total_length;
        logic [15:0] payload_length;
        logic [15:0] checksum_result;
        logic [31:0] source_address;
        logic [31:0] dest_address;
    } result_t;

    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [5:0]  MIN_HDR_BYTES  = 6'd20;
    localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;

endpackage

/* rtl/ihpc_front.sv */
// ----------------------------------------------------------------------------
// IPv4 header parser front end
// Tracks the byte offset, captures header fields, folds the header checksum
// and builds at most one result record per accepted item.
// ----------------------------------------------------------------------------
`include "ipv4_header_parse_check_core_assert.svh"

module ihpc_front
    import ihpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    output logic        push,
    output result_t     result
);

    logic [15:0] offset_reg, offset_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [7:0]  tos_reg, tos_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] tl_reg, tl_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic        malformed_reg, malformed_next;
    logic        done_reg, done_next;

    logic [16:0] word_sum;
    logic [15:0] sum_fold;
    logic [5:0]  hend;
    logic [16:0] offset_inc;

    assign word_sum   = {1'b0, sum_reg} + {1'b0, hold_reg, frame_byte};
    assign sum_fold   = word_sum[15:0] + {15'd0, word_sum[16]};
    assign offset_inc = {1'b0, offset_reg} + 17'd1;

    always_comb
    begin
        offset_next    = offset_reg;
        sum_next       = sum_reg;
        hold_next      = hold_reg;
        ihl_next       = ihl_reg;
        tos_next       = tos_reg;
        ttl_next       = ttl_reg;
        proto_next     = proto_reg;
        tl_next        = tl_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        malformed_next = malformed_reg;
        done_next      = done_reg;
        push           = 1'b0;
        result         = '0;
        hend           = MIN_HDR_BYTES;

        if (accept)
        begin
            if (!done_reg)
            begin
                unique case (offset_reg)
                    16'd0:   ihl_next = frame_byte[3:0];
                    16'd1:   tos_next = frame_byte;
                    16'd2:   tl_next[15:8] = frame_byte;
                    16'd3:   tl_next[7:0] = frame_byte;
                    16'd8:   ttl_next = frame_byte;
                    16'd9:   proto_next = frame_byte;
                    16'd12:  src_next[31:24] = frame_byte;
                    16'd13:  src_next[23:16] = frame_byte;
                    16'd14:  src_next[15:8] = frame_byte;
                    16'd15:  src_next[7:0] = frame_byte;
                    16'd16:  dst_next[31:24] = frame_byte;
                    16'd17:  dst_next[23:16] = frame_byte;
                    16'd18:  dst_next[15:8] = frame_byte;
                    16'd19:  dst_next[7:0] = frame_byte;
                    default: ;
                endcase

                if (!offset_reg[0])
                begin
                    hold_next = frame_byte;
                end
                else
                begin
                    sum_next = sum_fold;
                end

                hend = (ihl_next >= MIN_IHL) ? {ihl_next, 2'b00} : MIN_HDR_BYTES;

                if (offset_inc == {11'd0, hend})
                begin
                    done_next = 1'b1;
                    push      = 1'b1;
                    if (ihl_next < MIN_IHL || tl_next < {10'd0, hend})
                    begin
                        malformed_next = 1'b1;
                        result.kind    = KIND_MALFORMED;
                    end
                    else
                    begin
                        result.kind            = KIND_SUMMARY;
                        result.tos             = tos_next;
                        result.ttl             = ttl_next;
                        result.protocol        = proto_next;
                        result.header_bytes    = hend;
                        result.total_length    = tl_next;
                        result.payload_length  = tl_next - {10'd0, hend};
                        result.checksum_result = ~sum_next;
                        result.source_address  = src_next;
                        result.dest_address    = dst_next;
                    end
                end
                else if (frame_end)
                begin
                    push        = 1'b1;
                    result.kind = KIND_SHORT;
                end
            end
            else if (!malformed_reg && offset_reg < tl_reg)
            begin
                push                = 1'b1;
                result.kind         = KIND_PAYLOAD;
                result.payload_byte = frame_byte;
                result.payload_last = (offset_inc == {1'b0, tl_reg}) || frame_end;
            end

            if (frame_end)
            begin
                offset_next    = '0;
                sum_next       = '0;
                hold_next      = '0;
                ihl_next       = '0;
                tos_next       = '0;
                ttl_next       = '0;
                proto_next     = '0;
                tl_next        = '0;
                src_next       = '0;
                dst_next       = '0;
                malformed_next = 1'b0;
                done_next      = 1'b0;
            end
            else if (offset_reg != OFFSET_MAX)
            begin
                offset_next = offset_inc[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            sum_reg       <= '0;
            hold_reg      <= '0;
            ihl_reg       <= '0;
            tos_reg       <= '0;
            ttl_reg       <= '0;
            proto_reg     <= '0;
            tl_reg        <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            malformed_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            sum_reg       <= sum_next;
            hold_reg      <= hold_next;
            ihl_reg       <= ihl_next;
            tos_reg       <= tos_next;
            ttl_reg       <= ttl_next;
            proto_reg     <= proto_next;
            tl_reg        <= tl_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            malformed_reg <= malformed_next;
            done_reg      <= done_next;
        end
    end

    `IHPC_ASSERT_SAME(a_short_on_end, push && result.kind == KIND_SHORT, frame_end && !done_reg)
    `IHPC_ASSERT_NEXT(a_resolved_marks_done,
        push && !frame_end && (result.kind == KIND_SUMMARY || result.kind == KIND_MALFORMED),
        done_reg)
    `IHPC_ASSERT_SAME(a_payload_after_header, push && result.kind == KIND_PAYLOAD,
        done_reg && !malformed_reg)

endmodule

/* rtl/ihpc_queue.sv */
// ----------------------------------------------------------------------------
// IPv4 header parser result queue
// Small FIFO of result records between the parser and the output port.
// ----------------------------------------------------------------------------
`include "ipv4_header_parse_check_core_assert.svh"

module ihpc_queue
    import ihpc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign full      = (count_reg == FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `IHPC_ASSERT_SAME(a_count_bounded, 1'b1, count_reg <= FULL_CNT)
    `IHPC_ASSERT_SAME(a_no_push_when_full, full, !push)

endmodule

/* rtl/ipv4_header_parse_check_core.sv */
// ----------------------------------------------------------------------------
// IPv4 header parser with header checksum check
// Takes one packet byte per item and delivers payload bytes, a header summary
// or an error indication as result items.
// ----------------------------------------------------------------------------
// The input is held off only while the result queue is full. A byte's result,
// if it has one, is registered into that queue of QUEUE_DEPTH entries and
// offered on the output port from its head. With the output always ready and
// QUEUE_DEPTH above one, the block accepts one byte per clock cycle.
// The header checksum is folded one 16-bit word per odd byte.
module ipv4_header_parse_check_core
    import ihpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic        payload_last,
    output logic [7:0]  tos,
    output logic [7:0]  ttl,
    output logic [7:0]  protocol,
    output logic [5:0]  header_bytes,
    output logic [15:0] total_length,
    output logic [15:0] payload_length,
    output logic [15:0] checksum_result,
    output logic [31:0] source_address,
    output logic [31:0] dest_address
);

    logic    accept;
    logic    push;
    logic    full;
    result_t front_result;
    result_t head;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    ihpc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .push       (push),
        .result     (front_result)
    );

    ihpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_result),
        .full      (full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind            = head.kind;
    assign payload_byte    = head.payload_byte;
    assign payload_last    = head.payload_last;
    assign tos             = head.tos;
    assign ttl             = head.ttl;
    assign protocol        = head.protocol;
    assign header_bytes    = head.header_bytes;
    assign total_length    = head.total_length;
    assign payload_length  = head.payload_length;
    assign checksum_result = head.checksum_result;
    assign source_address  = head.source_address;
    assign dest_address    = head.dest_address;

endmodule
